// ===== design/assert_macros.svh =====
// assertion macros shared by the list store rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, suspended while reset is asserted
`define PLS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("list store assertion failed");

// checked property that also holds through reset
`define PLS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("list store assertion failed");

`endif

// ===== design/pls_pkg.sv =====
// shared types and constants of the positional list store
// no dependencies; used by the interfaces, the cell and the top level
`timescale 1ns / 1ps

package pls_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int WORD_BITS_DEF = 32;

    // fixed field widths of the request and response channels
    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    typedef enum logic {
        MODE_INSERT  = 1'b0,
        MODE_EXTRACT = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_EXTRACT
    } t_cell_op;

endpackage

// ===== design/pls_req_if.sv =====
// request and response channels of the positional list store
// depends on pls_pkg for the field widths
`timescale 1ns / 1ps

interface pls_req_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [pls_pkg::POS_W-1:0]  position;
    logic                       at_end;
    logic [pls_pkg::DATA_W-1:0] value;

    modport source (output valid, mode, position, at_end, value, input ready);
    modport sink   (input valid, mode, position, at_end, value, output ready);
endinterface

interface pls_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic [pls_pkg::DATA_W-1:0]  taken;
    logic [pls_pkg::COUNT_W-1:0] count;

    modport source (output valid, ok, taken, count, input ready);
    modport sink   (input valid, ok, taken, count, output ready);
endinterface

// ===== design/positional_list_store.sv =====
// Positional list store: an ordered list of up to CAPACITY words held in a row of cells, one
// word per cell. A request inserts a word at a position (later words move up one cell) or
// extracts the word at a position (later words move down one cell); at_end targets the back
// of the list. Every request gets one response with ok, the extracted word and the new count.
// One request is taken per clock unless a held response stalls: all cells shift in the same
// cycle, the extracted word is picked from the row through an OR tree, and the response sits
// in an output register, so a new request is taken while the previous response is being read
// or has been read. The store is empty right after reset; no clearing pass is needed.
// depends on pls_pkg, pls_req_if, pls_rsp_if, pls_cell and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module positional_list_store #(
    parameter int CAPACITY  = pls_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = pls_pkg::WORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pls_req_if.sink    i_req,
    pls_rsp_if.source  o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W;
    localparam int DW    = pls_pkg::DATA_W;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    logic                 r_ok;
    logic                 n_ok;
    logic [DW-1:0]        r_taken;
    logic [DW-1:0]        n_taken;

    logic                 w_accept;
    logic [CMP_W-1:0]     w_n;
    logic [CMP_W-1:0]     w_pos;
    logic [CMP_W-1:0]     w_eff_pos;
    logic                 w_ins_ok;
    logic                 w_ext_ok;
    pls_pkg::t_cell_op    w_op;
    logic [WORD_BITS-1:0] w_value;
    logic [WORD_BITS-1:0] w_pick;
    logic [WORD_BITS-1:0] w_word [CAPACITY];
    logic [WORD_BITS-1:0] w_sel  [CAPACITY];
    logic [DW-1:0]        w_pick_ext;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_n   = CMP_W'(r_count);
    assign w_pos = CMP_W'(i_req.position);

    // request decode
    always_comb begin
        w_eff_pos = w_pos;
        w_ins_ok  = 1'b0;
        w_ext_ok  = 1'b0;
        unique case (pls_pkg::t_mode'(i_req.mode))
            pls_pkg::MODE_INSERT: begin
                if (i_req.at_end) begin
                    w_eff_pos = w_n;
                end
                w_ins_ok = (w_n < CMP_W'(CAPACITY)) && (w_eff_pos <= w_n);
            end
            pls_pkg::MODE_EXTRACT: begin
                if (i_req.at_end) begin
                    w_eff_pos = w_n - CMP_W'(1);
                end
                w_ext_ok = (w_n != '0) && (w_eff_pos < w_n);
            end
            default: begin
                w_ins_ok = 1'b0;
                w_ext_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_op = pls_pkg::CELL_HOLD;
        if (w_accept && w_ins_ok) begin
            w_op = pls_pkg::CELL_INSERT;
        end else if (w_accept && w_ext_ok) begin
            w_op = pls_pkg::CELL_EXTRACT;
        end
    end

    generate
        if (WORD_BITS <= DW) begin : g_narrow
            assign w_value = i_req.value[WORD_BITS-1:0];
        end else begin : g_wide
            assign w_value = {{(WORD_BITS - DW){1'b0}}, i_req.value};
        end
    endgenerate

    // row of cells
    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            logic [WORD_BITS-1:0] w_lower;
            logic [WORD_BITS-1:0] w_upper;
            if (i == 0) begin : g_first
                assign w_lower = '0;
            end else begin : g_mid_lo
                assign w_lower = w_word[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign w_upper = '0;
            end else begin : g_mid_hi
                assign w_upper = w_word[i+1];
            end
            pls_cell #(
                .INDEX     (i),
                .WORD_BITS (WORD_BITS),
                .POS_BITS  (CMP_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (w_op),
                .i_pos   (w_eff_pos),
                .i_value (w_value),
                .i_lower (w_lower),
                .i_upper (w_upper),
                .o_word  (w_word[i]),
                .o_sel   (w_sel[i])
            );
        end
    endgenerate

    // at most one cell matches the position, so an OR picks its word
    always_comb begin
        w_pick = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_pick = w_pick | w_sel[i];
        end
    end

    generate
        if (WORD_BITS >= DW) begin : g_take_trunc
            assign w_pick_ext = w_pick[DW-1:0];
        end else begin : g_take_sext
            assign w_pick_ext = {{(DW - WORD_BITS){w_pick[WORD_BITS-1]}}, w_pick};
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        n_ok    = w_ins_ok || w_ext_ok;
        n_taken = w_ext_ok ? w_pick_ext : '0;
        if (w_ins_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ext_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok    <= n_ok;
            r_taken <= n_taken;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.ok    = r_ok;
    assign o_rsp.taken = r_taken;
    assign o_rsp.count = pls_pkg::COUNT_W'(r_count);

    `PLS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `PLS_ASSERT(a_rsp_follows, i_clk, i_rst_n, w_accept |=> r_out_valid)
    `PLS_ASSERT(a_insert_grows, i_clk, i_rst_n,
        (w_accept && w_ins_ok) |=> (r_count == $past(r_count) + CNT_W'(1)))
    `PLS_ASSERT(a_refused_zero, i_clk, i_rst_n,
        (r_out_valid && !r_ok) |-> (r_taken == '0))

endmodule

// ===== design/pls_cell.sv =====
// one slot of the list: holds a word and shifts with its neighbors
// depends on pls_pkg for the cell operation codes
`timescale 1ns / 1ps

module pls_cell #(
    parameter int INDEX     = 0,
    parameter int WORD_BITS = pls_pkg::WORD_BITS_DEF,
    parameter int POS_BITS  = pls_pkg::POS_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pls_pkg::t_cell_op     i_op,
    input  logic [POS_BITS-1:0]   i_pos,
    input  logic [WORD_BITS-1:0]  i_value,
    input  logic [WORD_BITS-1:0]  i_lower,
    input  logic [WORD_BITS-1:0]  i_upper,
    output logic [WORD_BITS-1:0]  o_word,
    output logic [WORD_BITS-1:0]  o_sel
);

    localparam int unsigned Idx = INDEX;

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic                 w_at;
    logic                 w_above;

    assign w_at    = (Idx == 32'(i_pos));
    assign w_above = (Idx > 32'(i_pos));

    always_comb begin
        n_word = r_word;
        case (i_op)
            pls_pkg::CELL_INSERT: begin
                if (w_at) begin
                    n_word = i_value;
                end else if (w_above) begin
                    n_word = i_lower;
                end
            end
            // the top cell pulls in zero, which clears the vacated slot
            pls_pkg::CELL_EXTRACT: begin
                if (w_at || w_above) begin
                    n_word = i_upper;
                end
            end
            default: n_word = r_word;
        endcase
    end

    // cleared at reset so every slot above the count holds zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;
    assign o_sel  = w_at ? r_word : '0;

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for positional_list_store: random and directed insert/extract requests
// checked against an in-bench model of the ordered list
// depends on pls_pkg, pls_req_if, pls_rsp_if and the positional_list_store rtl
`timescale 1ns / 1ps

module testbench;

    localparam int LIST_CAP    = pls_pkg::CAPACITY_DEF;
    localparam int POS_W       = pls_pkg::POS_W;
    localparam int DATA_W      = pls_pkg::DATA_W;
    localparam int COUNT_W     = pls_pkg::COUNT_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int STALL_LEN   = 300;

    typedef struct packed {
        pls_pkg::t_mode     mode;
        logic [POS_W-1:0]   position;
        logic               at_end;
        logic [DATA_W-1:0]  value;
    } t_list_request;

    typedef struct packed {
        logic               ok;
        logic [DATA_W-1:0]  taken;
        logic [COUNT_W-1:0] count;
    } t_list_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pls_req_if req_ch ();
    pls_rsp_if rsp_ch ();

    positional_list_store uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model of the list, advanced on every accepted request
    logic [DATA_W-1:0] model_words [LIST_CAP];
    int                model_len;

    t_list_request     pending_reqs [$];
    t_list_answer      expected_answers [$];
    t_list_request     offered_req;
    int                reqs_offered  = 0;
    int                reqs_accepted = 0;
    int                answers_seen  = 0;
    int                mismatches    = 0;
    int                cycle_cnt     = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    logic              sender_hold   = 1'b0;
    logic              stall_start   = 1'b0;
    int                stall_left    = 0;
    int                gen_len       = 0;

    function automatic t_list_answer apply_request(t_list_request r);
        t_list_answer ans;
        int n;
        int p;
        ans = '0;
        n = model_len;
        p = int'(r.position);
        if (r.mode == pls_pkg::MODE_INSERT) begin
            if (r.at_end) p = n;
            if (n < LIST_CAP && p <= n) begin
                for (int i = n; i > p; i--) model_words[i] = model_words[i-1];
                model_words[p] = r.value;
                model_len = n + 1;
                ans.ok = 1'b1;
            end
        end else if (n > 0) begin
            if (r.at_end) p = n - 1;
            if (p < n) begin
                ans.taken = model_words[p];
                for (int i = p; i + 1 < n; i++) model_words[i] = model_words[i+1];
                model_words[n-1] = '0;
                model_len = n - 1;
                ans.ok = 1'b1;
            end
        end
        ans.count = COUNT_W'(model_len);
        return ans;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("mismatch in %s at response %0d: got %h, expected %h",
                 what, answers_seen, got, want);
        mismatches++;
    endtask

    // queue a request and keep a running count so random positions can aim at the live range
    task automatic queue_request(pls_pkg::t_mode mode, int pos, logic at_end,
                                 logic [DATA_W-1:0] value);
        t_list_request r;
        int p;
        r.mode = mode;
        r.position = POS_W'(pos);
        r.at_end = at_end;
        r.value = value;
        pending_reqs.push_back(r);
        p = at_end ? -1 : int'(r.position);
        if (mode == pls_pkg::MODE_INSERT) begin
            if (at_end) p = gen_len;
            if (gen_len < LIST_CAP && p <= gen_len) gen_len++;
        end else if (gen_len > 0) begin
            if (at_end) p = gen_len - 1;
            if (p < gen_len) gen_len--;
        end
    endtask

    task automatic queue_random(int insert_pct);
        pls_pkg::t_mode mode;
        int sel;
        int pos;
        logic at_end;
        logic [DATA_W-1:0] value;
        mode = ($urandom_range(99) < insert_pct) ? pls_pkg::MODE_INSERT
                                                 : pls_pkg::MODE_EXTRACT;
        sel = $urandom_range(99);
        at_end = 1'b0;
        if (sel < 15) begin
            at_end = 1'b1;
            pos = $urandom_range(127);
        end else if (sel < 25) begin
            pos = $urandom_range(127);
        end else if (sel < 32) begin
            pos = gen_len;
        end else if (gen_len == 0) begin
            pos = 0;
        end else begin
            pos = $urandom_range(mode == pls_pkg::MODE_INSERT ? gen_len : gen_len - 1);
        end
        case ($urandom_range(19))
            0: value = 32'h7fff_ffff;
            1: value = 32'h8000_0000;
            2: value = 32'hffff_ffff;
            3: value = 32'h0000_0000;
            default: value = $urandom;
        endcase
        queue_request(mode, pos, at_end, value);
    endtask

    // segments with a drifting insert bias walk the list between empty and full
    task automatic queue_phase(int n_items);
        int bias;
        for (int k = 0; k < n_items; k++) begin
            if (k % 50 == 0) begin
                case ($urandom_range(3))
                    0: bias = 15;
                    1: bias = 50;
                    2: bias = 85;
                    default: bias = 95;
                endcase
            end
            queue_random(bias);
        end
    endtask

    task automatic drain_all();
        while (pending_reqs.size() > 0 || reqs_offered != reqs_accepted
               || expected_answers.size() > 0)
            @(posedge i_clk);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (reqs_offered == reqs_accepted) begin
            if (pending_reqs.size() > 0 && !sender_hold
                && $urandom_range(99) >= send_idle_pct) begin
                offered_req = pending_reqs.pop_front();
                reqs_offered++;
                req_ch.valid    <= 1'b1;
                req_ch.mode     <= offered_req.mode;
                req_ch.position <= offered_req.position;
                req_ch.at_end   <= offered_req.at_end;
                req_ch.value    <= offered_req.value;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response side back-pressure
    always @(negedge i_clk) begin
        rsp_ch.ready <= i_rst_n && stall_left == 0 && $urandom_range(99) >= recv_idle_pct;
    end

    always @(posedge i_clk) begin
        if (stall_start) stall_left <= STALL_LEN;
        else if (stall_left > 0) stall_left <= stall_left - 1;
    end

    // request and response monitor
    always @(posedge i_clk) begin
        t_list_answer want;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            expected_answers.push_back(apply_request(offered_req));
            reqs_accepted++;
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected response", rsp_ch.taken, '0);
            end else begin
                want = expected_answers.pop_front();
                if (rsp_ch.ok !== want.ok)
                    report_mismatch("ok", DATA_W'(rsp_ch.ok), DATA_W'(want.ok));
                if (rsp_ch.taken !== want.taken)
                    report_mismatch("taken", rsp_ch.taken, want.taken);
                if (rsp_ch.count !== want.count)
                    report_mismatch("count", DATA_W'(rsp_ch.count), DATA_W'(want.count));
            end
            answers_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.mode = pls_pkg::MODE_INSERT;
        req_ch.position = '0;
        req_ch.at_end = 1'b0;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < LIST_CAP; i++) model_words[i] = '0;
        model_len = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: refusals on empty, bad positions, word extremes, front/back/middle moves
        send_idle_pct = 13;
        recv_idle_pct = 72;
        queue_request(pls_pkg::MODE_EXTRACT, 0, 1'b0, 32'h1234_5678);
        queue_request(pls_pkg::MODE_EXTRACT, 0, 1'b1, '0);
        queue_request(pls_pkg::MODE_INSERT, 1, 1'b0, 32'd5);
        queue_request(pls_pkg::MODE_INSERT, 127, 1'b0, 32'd6);
        queue_request(pls_pkg::MODE_INSERT, 0, 1'b1, 32'h7fff_ffff);
        queue_request(pls_pkg::MODE_INSERT, 0, 1'b0, 32'h8000_0000);
        queue_request(pls_pkg::MODE_INSERT, 1, 1'b0, 32'hffff_ffff);
        queue_request(pls_pkg::MODE_INSERT, 3, 1'b0, 32'h0000_0000);
        queue_request(pls_pkg::MODE_INSERT, 64, 1'b0, 32'd1);
        queue_request(pls_pkg::MODE_INSERT, 127, 1'b1, 32'h5555_5555);
        queue_request(pls_pkg::MODE_EXTRACT, 5, 1'b0, '0);
        queue_request(pls_pkg::MODE_EXTRACT, 127, 1'b0, '0);
        queue_request(pls_pkg::MODE_EXTRACT, 1, 1'b0, '0);
        queue_request(pls_pkg::MODE_EXTRACT, 127, 1'b1, '0);
        queue_request(pls_pkg::MODE_EXTRACT, 0, 1'b0, '0);
        queue_request(pls_pkg::MODE_INSERT, 2, 1'b0, 32'haaaa_aaaa);
        queue_request(pls_pkg::MODE_EXTRACT, 3, 1'b0, '0);
        queue_request(pls_pkg::MODE_EXTRACT, 0, 1'b0, '0);
        queue_request(pls_pkg::MODE_EXTRACT, 0, 1'b0, '0);
        queue_request(pls_pkg::MODE_EXTRACT, 0, 1'b0, '0);
        queue_request(pls_pkg::MODE_EXTRACT, 0, 1'b0, '0);
        drain_all();

        // sparse sender, slow receiver
        send_idle_pct = 13;
        recv_idle_pct = 72;
        queue_phase(460);
        drain_all();

        // slow sender, sparse receiver; sender pauses midway until all responses are in
        send_idle_pct = 72;
        recv_idle_pct = 13;
        queue_phase(470);
        while (pending_reqs.size() > 230) @(posedge i_clk);
        @(negedge i_clk);
        sender_hold = 1'b1;
        while (reqs_offered != reqs_accepted || expected_answers.size() > 0)
            @(posedge i_clk);
        @(negedge i_clk);
        sender_hold = 1'b0;
        drain_all();

        // full rate, with one long receiver stall while requests keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_phase(470);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        stall_start = 1'b1;
        @(negedge i_clk);
        stall_start = 1'b0;
        drain_all();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/pls_pkg.sv
design/pls_req_if.sv
design/pls_cell.sv
design/positional_list_store.sv
bench/testbench.sv
